// File: sv/backward_lz_bit_unpacker_top_defines.svh
// ----------------------------------------------------------------------------
// backward lz bit unpacker assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef BACKWARD_LZ_BIT_UNPACKER_TOP_DEFINES_SVH
`define BACKWARD_LZ_BIT_UNPACKER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BLU_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("blu port check failed");

// next-cycle implication
`define BLU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("blu port check failed");

`endif

// File: sv/blu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blu_pkg
// types and constants shared by the backward lz bit unpacker
// ----------------------------------------------------------------------------
package blu_pkg;

	localparam int unsigned HIST_DEPTH_DEF   = 4096;
	localparam int unsigned BYTES_PER_RESULT = 16;
	localparam int unsigned CNT_W            = 5;

	localparam logic [31:0] SENTINEL     = 32'h8000_0000;
	localparam logic [3:0]  LEN_CODE2    = 4'd2;
	localparam logic [3:0]  LEN_LIT_SHORT = 4'd3;
	localparam logic [3:0]  LEN_BYTE     = 4'd8;
	localparam logic [3:0]  LEN_OFF_LONG = 4'd12;
	localparam logic [3:0]  LEN_OFF_BASE = 4'd9;

	typedef enum logic {
		ITEM_WORD,
		ITEM_START
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] word;
	} item_t;

	typedef enum logic [1:0] {
		HDR_IDLE,
		HDR_CHECK,
		HDR_FIRST,
		HDR_DATA
	} hdr_t;

	typedef enum logic [2:0] {
		PH_PFX_A,
		PH_PFX_B,
		PH_CODE2,
		PH_LITCNT,
		PH_LITBYTE,
		PH_COPYLEN,
		PH_COPYOFF
	} phase_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DECODE,
		BK_COPY_RD,
		BK_COPY_WR,
		BK_FINISH
	} bk_state_t;

endpackage

// File: sv/blu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blu_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module blu_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4096,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: sv/blu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blu_front
// accepts packed words, tags stream starts, two entry queue to the back end
// ----------------------------------------------------------------------------
module blu_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            word_valid,
	output logic            word_stall,
	input  logic            stream_start,
	input  logic [31:0]     packed_word,
	output logic            q_valid,
	output blu_pkg::item_t  q_item,
	input  logic            q_pop
);
	import blu_pkg::*;

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;

	assign word_stall = (fill_q == 2'd2);
	assign push       = word_valid && !word_stall;
	assign q_valid    = (fill_q != 2'd0);
	assign q_item     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= '{kind: (stream_start ? ITEM_START : ITEM_WORD),
				word: packed_word};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

// File: sv/blu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blu_back
// serial command decoder, copy engine over the history ram, result packer
// ----------------------------------------------------------------------------
module blu_back #(
	parameter int unsigned HISTORY_DEPTH = blu_pkg::HIST_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  blu_pkg::item_t              q_item,
	output logic                        q_pop,
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic [63:0]                 bytes_low,
	output logic [63:0]                 bytes_high,
	output logic [blu_pkg::CNT_W-1:0]   byte_count,
	output logic                        last_for_word,
	output logic                        stream_done,
	output logic                        check_ok,
	output logic                        format_error
);
	import blu_pkg::*;

	localparam int unsigned AW = $clog2(HISTORY_DEPTH);
	localparam int unsigned PW = AW + 1;

	bk_state_t   state_q, state_d;
	hdr_t        hdr_q, hdr_d;
	phase_t      ph_q, ph_d;
	logic [31:0] shifter_q, shifter_d;
	logic [31:0] check_q, check_d;
	logic [31:0] left_q, left_d;
	logic [11:0] facc_q, facc_d;
	logic [3:0]  fleft_q, fleft_d;
	logic [8:0]  run_q, run_d;
	logic [PW-1:0] dist_q, dist_d;
	logic [AW-1:0] wp_q, wp_d;
	logic [PW-1:0] prod_q, prod_d;
	logic        serr_q, serr_d;
	logic        avail_q, avail_d;
	logic        done_q, done_d;
	logic [CNT_W-1:0] pcnt_q, pcnt_d;
	logic        perr_q, perr_d;
	logic [31:0] word_q, word_d;
	logic [7:0]  pend_q [BYTES_PER_RESULT];
	logic [7:0]  pend_d [BYTES_PER_RESULT];
	logic        out_valid_q;

	logic        can_push;
	logic        emit;
	logic [7:0]  emit_val;
	logic        ram_rd;
	logic [7:0]  ram_rdata;
	logic [AW-1:0] copy_addr;
	logic [PW-1:0] wp_ext;
	logic        load_out;
	logic        load_last;
	logic [63:0] pack_lo, pack_hi;
	logic [CNT_W-1:0] load_cnt;

	assign can_push  = !out_valid_q || !res_stall;
	assign res_valid = out_valid_q;
	assign wp_ext    = {1'b0, wp_q};

	always_comb begin
		if (wp_ext >= dist_q) begin
			copy_addr = AW'(wp_ext - dist_q);
		end else begin
			copy_addr = AW'(wp_ext + PW'(HISTORY_DEPTH) - dist_q);
		end
	end

	blu_ram #(
		.WIDTH (8),
		.DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk     (clk),
		.wr_en   (emit),
		.wr_addr (wp_q),
		.wr_data (emit_val),
		.rd_en   (ram_rd),
		.rd_addr (copy_addr),
		.rd_data (ram_rdata)
	);

	// masked view of the pending bytes
	always_comb begin
		pack_lo = '0;
		pack_hi = '0;
		for (int i = 0; i < 8; i++) begin
			if (CNT_W'(i) < load_cnt) begin
				pack_lo[8*i +: 8] = pend_q[i];
			end
			if (CNT_W'(i + 8) < load_cnt) begin
				pack_hi[8*i +: 8] = pend_q[i + 8];
			end
		end
	end

	always_comb begin
		logic        bit_v;
		logic [11:0] acc_v;
		logic [3:0]  lft_v;
		logic [8:0]  run_v;
		logic [31:0] left_v;
		logic [PW-1:0] dd_v;
		logic        end_v;
		logic        blocked;

		state_d   = state_q;
		hdr_d     = hdr_q;
		ph_d      = ph_q;
		shifter_d = shifter_q;
		check_d   = check_q;
		left_d    = left_q;
		facc_d    = facc_q;
		fleft_d   = fleft_q;
		run_d     = run_q;
		dist_d    = dist_q;
		wp_d      = wp_q;
		prod_d    = prod_q;
		serr_d    = serr_q;
		avail_d   = avail_q;
		done_d    = done_q;
		pcnt_d    = pcnt_q;
		perr_d    = perr_q;
		word_d    = word_q;
		pend_d    = pend_q;
		q_pop     = 1'b0;
		emit      = 1'b0;
		emit_val  = '0;
		ram_rd    = 1'b0;
		load_out  = 1'b0;
		load_last = 1'b0;
		load_cnt  = pcnt_q;
		bit_v     = 1'b0;
		acc_v     = '0;
		lft_v     = '0;
		run_v     = run_q;
		left_v    = left_q;
		dd_v      = '0;
		end_v     = 1'b0;
		blocked   = (ph_q == PH_LITBYTE) && (fleft_q <= 4'd1) &&
			(pcnt_q == CNT_W'(BYTES_PER_RESULT)) && !can_push;

		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					q_pop  = 1'b1;
					pcnt_d = '0;
					done_d = 1'b0;
					if (q_item.kind == ITEM_START) begin
						shifter_d = '0;
						check_d   = '0;
						left_d    = q_item.word;
						hdr_d     = HDR_CHECK;
						ph_d      = PH_PFX_A;
						facc_d    = '0;
						fleft_d   = '0;
						run_d     = '0;
						dist_d    = '0;
						wp_d      = '0;
						prod_d    = '0;
						serr_d    = 1'b0;
						state_d   = BK_FINISH;
					end else begin
						unique case (hdr_q)
							HDR_CHECK: begin
								check_d = q_item.word;
								hdr_d   = HDR_FIRST;
								state_d = BK_FINISH;
							end
							HDR_FIRST: begin
								check_d   = check_q ^ q_item.word;
								shifter_d = q_item.word;
								hdr_d     = HDR_DATA;
								ph_d      = PH_PFX_A;
								avail_d   = 1'b0;
								state_d   = BK_DECODE;
							end
							HDR_DATA: begin
								word_d  = q_item.word;
								avail_d = 1'b1;
								state_d = BK_DECODE;
							end
							HDR_IDLE: begin
								state_d = BK_FINISH;
							end
						endcase
					end
				end
			end

			BK_DECODE: begin
				if (shifter_q <= 32'd1 && !avail_q) begin
					state_d = BK_FINISH;
				end else if (!blocked) begin
					// marker bit left only: pull in the queued word
					if (shifter_q <= 32'd1) begin
						bit_v     = word_q[0];
						shifter_d = SENTINEL | (word_q >> 1);
						check_d   = check_q ^ word_q;
						avail_d   = 1'b0;
					end else begin
						bit_v     = shifter_q[0];
						shifter_d = shifter_q >> 1;
					end
					unique case (ph_q)
						PH_PFX_A: begin
							if (bit_v) begin
								ph_d    = PH_CODE2;
								fleft_d = LEN_CODE2;
								facc_d  = '0;
							end else begin
								ph_d = PH_PFX_B;
							end
						end
						PH_PFX_B: begin
							facc_d = '0;
							if (!bit_v) begin
								run_d   = 9'd1;
								ph_d    = PH_LITCNT;
								fleft_d = LEN_LIT_SHORT;
							end else begin
								run_d   = 9'd2;
								ph_d    = PH_COPYOFF;
								fleft_d = LEN_BYTE;
							end
						end
						default: begin
							acc_v   = {facc_q[10:0], bit_v};
							lft_v   = (fleft_q != 4'd0) ? fleft_q - 4'd1 : 4'd0;
							facc_d  = acc_v;
							fleft_d = lft_v;
							if (lft_v == 4'd0) begin
								unique case (ph_q)
									PH_CODE2: begin
										facc_d = '0;
										if (acc_v == 12'd3) begin
											run_d   = 9'd9;
											ph_d    = PH_LITCNT;
											fleft_d = LEN_BYTE;
										end else if (acc_v < 12'd2) begin
											run_d   = 9'(acc_v[0]) + 9'd3;
											ph_d    = PH_COPYOFF;
											fleft_d = 4'(acc_v[0]) + LEN_OFF_BASE;
										end else begin
											ph_d    = PH_COPYLEN;
											fleft_d = LEN_BYTE;
										end
									end
									PH_LITCNT: begin
										run_v = run_q + {1'b0, acc_v[7:0]};
										if (32'(run_v) > left_q) begin
											run_v  = left_q[8:0];
											serr_d = 1'b1;
										end
										left_v = left_q - 32'(run_v);
										left_d = left_v;
										run_d  = run_v;
										if (run_v == 9'd0) begin
											end_v = 1'b1;
										end else begin
											ph_d    = PH_LITBYTE;
											fleft_d = LEN_BYTE;
											facc_d  = '0;
										end
									end
									PH_LITBYTE: begin
										emit     = 1'b1;
										emit_val = acc_v[7:0];
										run_v    = (run_q != 9'd0) ? run_q - 9'd1 : 9'd0;
										run_d    = run_v;
										if (run_v == 9'd0) begin
											end_v = 1'b1;
										end else begin
											fleft_d = LEN_BYTE;
											facc_d  = '0;
										end
									end
									PH_COPYLEN: begin
										run_d   = {1'b0, acc_v[7:0]} + 9'd1;
										ph_d    = PH_COPYOFF;
										fleft_d = LEN_OFF_LONG;
										facc_d  = '0;
									end
									PH_COPYOFF: begin
										if (32'(run_q) > left_q) begin
											run_v  = left_q[8:0];
											serr_d = 1'b1;
										end
										left_v = left_q - 32'(run_v);
										left_d = left_v;
										run_d  = run_v;
										dd_v   = PW'(acc_v);
										// zero or too far back: clamp and flag
										if (dd_v == '0 || dd_v > prod_q) begin
											serr_d = 1'b1;
											dd_v   = (dd_v == '0 || prod_q == '0) ? PW'(1) : prod_q;
										end
										dist_d = dd_v;
										if (run_v != 9'd0) begin
											state_d = BK_COPY_RD;
										end else begin
											end_v = 1'b1;
										end
									end
									default: begin
										ph_d = PH_PFX_A;
									end
								endcase
							end
						end
					endcase
					if (end_v) begin
						if (left_v == 32'd0) begin
							hdr_d   = HDR_IDLE;
							done_d  = 1'b1;
							state_d = BK_FINISH;
						end else begin
							ph_d = PH_PFX_A;
						end
					end
				end
			end

			BK_COPY_RD: begin
				ram_rd  = 1'b1;
				state_d = BK_COPY_WR;
			end

			BK_COPY_WR: begin
				if (!(pcnt_q == CNT_W'(BYTES_PER_RESULT) && !can_push)) begin
					emit     = 1'b1;
					emit_val = (prod_q == '0) ? 8'd0 : ram_rdata;
					run_v    = run_q - 9'd1;
					run_d    = run_v;
					if (run_v == 9'd0) begin
						if (left_q == 32'd0) begin
							hdr_d   = HDR_IDLE;
							done_d  = 1'b1;
							state_d = BK_FINISH;
						end else begin
							ph_d    = PH_PFX_A;
							state_d = BK_DECODE;
						end
					end else begin
						state_d = BK_COPY_RD;
					end
				end
			end

			BK_FINISH: begin
				if (can_push) begin
					load_out  = 1'b1;
					load_last = 1'b1;
					state_d   = BK_IDLE;
				end
			end

			default: begin
				state_d = BK_IDLE;
			end
		endcase

		// byte into history and result buffer; a full buffer leaves first
		if (emit) begin
			wp_d = (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (prod_q < PW'(HISTORY_DEPTH)) begin
				prod_d = prod_q + PW'(1);
			end
			perr_d = serr_q;
			if (pcnt_q == CNT_W'(BYTES_PER_RESULT)) begin
				load_out  = 1'b1;
				pend_d[0] = emit_val;
				pcnt_d    = CNT_W'(1);
			end else begin
				pend_d[pcnt_q[CNT_W-2:0]] = emit_val;
				pcnt_d = pcnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			hdr_q       <= HDR_IDLE;
			ph_q        <= PH_PFX_A;
			shifter_q   <= '0;
			check_q     <= '0;
			left_q      <= '0;
			facc_q      <= '0;
			fleft_q     <= '0;
			run_q       <= '0;
			dist_q      <= '0;
			wp_q        <= '0;
			prod_q      <= '0;
			serr_q      <= 1'b0;
			avail_q     <= 1'b0;
			done_q      <= 1'b0;
			pcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			hdr_q     <= hdr_d;
			ph_q      <= ph_d;
			shifter_q <= shifter_d;
			check_q   <= check_d;
			left_q    <= left_d;
			facc_q    <= facc_d;
			fleft_q   <= fleft_d;
			run_q     <= run_d;
			dist_q    <= dist_d;
			wp_q      <= wp_d;
			prod_q    <= prod_d;
			serr_q    <= serr_d;
			avail_q   <= avail_d;
			done_q    <= done_d;
			pcnt_q    <= pcnt_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
		pend_q <= pend_d;
		perr_q <= perr_d;
		if (load_out) begin
			bytes_low     <= pack_lo;
			bytes_high    <= pack_hi;
			byte_count    <= load_cnt;
			last_for_word <= load_last;
			stream_done   <= load_last && done_q;
			check_ok      <= load_last && done_q && (check_q == 32'd0);
			format_error  <= load_last ? serr_q : perr_q;
		end
	end

endmodule

// File: sv/backward_lz_bit_unpacker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// backward_lz_bit_unpacker_top
// unpacks a backward lz bit stream word by word into 16 byte results
// ----------------------------------------------------------------------------
//  channel   direction  handshake                payload
//  word      in         word_valid / word_stall  stream_start, packed_word
//  res       out        res_valid / res_stall    bytes_low, bytes_high, byte_count,
//                                                last_for_word, stream_done,
//                                                check_ok, format_error
//
// a word leaves the queue, then the serial bit decoder takes its bits one at a
// time; each copied byte is a read and then a write of the history ram, and a
// closing result follows once the shifter is found empty. the serial bit
// decoder and the single read port of the history ram set the pace; the back
// end takes no new word from the queue until its closing result is loaded.
// reset clears all control state; history contents are not cleared.
// a stalled result holds the back end only when the next result is due.
// ----------------------------------------------------------------------------
module backward_lz_bit_unpacker_top #(
	parameter int unsigned HISTORY_DEPTH = blu_pkg::HIST_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      word_valid,
	output logic                      word_stall,
	input  logic                      stream_start,
	input  logic [31:0]               packed_word,
	output logic                      res_valid,
	input  logic                      res_stall,
	output logic [63:0]               bytes_low,
	output logic [63:0]               bytes_high,
	output logic [blu_pkg::CNT_W-1:0] byte_count,
	output logic                      last_for_word,
	output logic                      stream_done,
	output logic                      check_ok,
	output logic                      format_error
);
	import blu_pkg::*;

	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	blu_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.word_valid   (word_valid),
		.word_stall   (word_stall),
		.stream_start (stream_start),
		.packed_word  (packed_word),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop)
	);

	blu_back #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.bytes_low     (bytes_low),
		.bytes_high    (bytes_high),
		.byte_count    (byte_count),
		.last_for_word (last_for_word),
		.stream_done   (stream_done),
		.check_ok      (check_ok),
		.format_error  (format_error)
	);

endmodule

// File: sv/blu_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blu_chk
// port level checks on the result channel of the unpacker
// ----------------------------------------------------------------------------
`include "backward_lz_bit_unpacker_top_defines.svh"

module blu_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_stall,
	input logic [63:0] bytes_low,
	input logic [63:0] bytes_high,
	input logic [4:0]  byte_count,
	input logic        last_for_word,
	input logic        stream_done,
	input logic        check_ok
);

	// a stalled result keeps its bytes
	`BLU_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(bytes_low) && $stable(bytes_high) && $stable(byte_count))

	`BLU_ASSERT_NOW(a_count_range, res_valid, byte_count <= 5'd16)

	// only the closing result of a word may be short
	`BLU_ASSERT_NOW(a_full_unless_last, res_valid && !last_for_word, byte_count == 5'd16)

	`BLU_ASSERT_NOW(a_done_is_last, res_valid && stream_done, last_for_word)

	`BLU_ASSERT_NOW(a_ok_needs_done, res_valid && check_ok, stream_done)

endmodule

bind backward_lz_bit_unpacker_top blu_chk u_chk (.*);

// File: verif/backward_lz_bit_unpacker_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// backward_lz_bit_unpacker_checker
// watches both channels, predicts the unpacked byte results of every accepted
// word request and compares each accepted result field by field, in order
// ----------------------------------------------------------------------------
module backward_lz_bit_unpacker_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        word_valid,
	input  logic        word_stall,
	input  logic        stream_start,
	input  logic [31:0] packed_word,
	input  logic        res_valid,
	input  logic        res_stall,
	input  logic [63:0] bytes_low,
	input  logic [63:0] bytes_high,
	input  logic [4:0]  byte_count,
	input  logic        last_for_word,
	input  logic        stream_done,
	input  logic        check_ok,
	input  logic        format_error,
	output int          fail_count,
	output int          pending
);
	import blu_pkg::*;

	localparam int unsigned HDEPTH  = HIST_DEPTH_DEF;
	localparam int unsigned MAX_RES = 34;

	typedef struct {
		logic [63:0] lo;
		logic [63:0] hi;
		logic [4:0]  cnt;
		logic        last;
		logic        done;
		logic        ok;
		logic        err;
	} unpacked_t;

	unpacked_t   unpacked_q[$];

	logic [7:0]  hist [HDEPTH];
	logic [31:0] shifter, chk_acc, left, run_len, distance;
	hdr_t        hdr;
	phase_t      phase;
	logic [11:0] facc;
	int unsigned fbits, wr_ptr, produced, n_res, n_pend;
	logic        err_flag, word_avail;
	logic [7:0]  pend [BYTES_PER_RESULT];

	function automatic void flush_result();
		unpacked_t r;
		if (n_res >= MAX_RES) begin
			n_pend = 0;
			return;
		end
		r.lo = '0;
		r.hi = '0;
		for (int i = 0; i < n_pend; i++) begin
			if (i < 8)
				r.lo[8*i +: 8] = pend[i];
			else
				r.hi[8*(i-8) +: 8] = pend[i];
		end
		r.cnt = 5'(n_pend);
		r.last = 1'b0;
		r.done = 1'b0;
		r.ok = 1'b0;
		r.err = err_flag;
		unpacked_q.push_back(r);
		n_res++;
		n_pend = 0;
	endfunction

	function automatic void put_byte(input logic [7:0] b);
		hist[wr_ptr] = b;
		wr_ptr = (wr_ptr + 1 >= HDEPTH) ? 0 : wr_ptr + 1;
		if (produced < HDEPTH)
			produced++;
		pend[n_pend] = b;
		n_pend++;
		if (n_pend >= BYTES_PER_RESULT)
			flush_result();
	endfunction

	function automatic logic next_bit(input logic [31:0] w, output logic b);
		if (shifter <= 32'd1) begin
			if (!word_avail)
				return 1'b0;
			word_avail = 1'b0;
			chk_acc ^= w;
			b = w[0];
			shifter = (w >> 1) | SENTINEL;
			return 1'b1;
		end
		b = shifter[0];
		shifter = shifter >> 1;
		return 1'b1;
	endfunction

	function automatic void open_field(input phase_t p, input int unsigned n);
		phase = p;
		fbits = n;
		facc = '0;
	endfunction

	function automatic void charge_size();
		if (run_len > left) begin
			run_len = left;
			err_flag = 1'b1;
		end
		left -= run_len;
	endfunction

	function automatic void copy_bytes();
		int unsigned d;
		logic [7:0]  b;
		d = distance;
		if (d == 0 || d > produced) begin
			err_flag = 1'b1;
			d = (d == 0 || produced == 0) ? 1 : produced;
		end
		for (int unsigned n = 0; n < run_len; n++) begin
			b = 8'h00;
			if (produced != 0)
				b = hist[(wr_ptr + HDEPTH - d) % HDEPTH];
			put_byte(b);
		end
	endfunction

	// walks the command bits until the word runs dry or the stream ends
	function automatic logic decode_bits(input logic [31:0] w);
		logic        b, fin;
		logic [11:0] v;
		while (1) begin
			fin = 1'b0;
			if (!next_bit(w, b))
				return 1'b0;
			if (phase == PH_PFX_A) begin
				if (b)
					open_field(PH_CODE2, 2);
				else
					phase = PH_PFX_B;
				continue;
			end
			if (phase == PH_PFX_B) begin
				if (!b) begin
					run_len = 1;
					open_field(PH_LITCNT, 3);
				end else begin
					run_len = 2;
					open_field(PH_COPYOFF, 8);
				end
				continue;
			end
			facc = {facc[10:0], b};
			if (fbits > 0)
				fbits--;
			if (fbits != 0)
				continue;
			v = facc;
			case (phase)
				PH_CODE2: begin
					if (v == 3) begin
						run_len = 9;
						open_field(PH_LITCNT, 8);
					end else if (v < 2) begin
						run_len = 32'(v) + 32'd3;
						open_field(PH_COPYOFF, 32'(v) + 32'd9);
					end else begin
						open_field(PH_COPYLEN, 8);
					end
				end
				PH_LITCNT: begin
					run_len += 32'(v);
					charge_size();
					if (run_len == 0)
						fin = 1'b1;
					else
						open_field(PH_LITBYTE, 8);
				end
				PH_LITBYTE: begin
					put_byte(v[7:0]);
					if (run_len > 0)
						run_len--;
					if (run_len == 0)
						fin = 1'b1;
					else
						open_field(PH_LITBYTE, 8);
				end
				PH_COPYLEN: begin
					run_len = 32'(v) + 32'd1;
					open_field(PH_COPYOFF, 12);
				end
				PH_COPYOFF: begin
					distance = 32'(v);
					charge_size();
					copy_bytes();
					fin = 1'b1;
				end
				default: phase = PH_PFX_A;
			endcase
			if (fin) begin
				if (left == 0) begin
					hdr = HDR_IDLE;
					return 1'b1;
				end
				phase = PH_PFX_A;
			end
		end
		return 1'b0;
	endfunction

	function automatic void unpack_word(input logic start, input logic [31:0] w);
		logic done;
		int   k;
		n_res = 0;
		n_pend = 0;
		done = 1'b0;
		if (start) begin
			shifter = '0;
			chk_acc = '0;
			left = w;
			hdr = HDR_CHECK;
			phase = PH_PFX_A;
			facc = '0;
			fbits = 0;
			run_len = '0;
			distance = '0;
			wr_ptr = 0;
			produced = 0;
			err_flag = 1'b0;
		end else if (hdr == HDR_CHECK) begin
			chk_acc = w;
			hdr = HDR_FIRST;
		end else if (hdr == HDR_FIRST) begin
			chk_acc ^= w;
			shifter = w;
			hdr = HDR_DATA;
			phase = PH_PFX_A;
			word_avail = 1'b0;
			done = decode_bits('0);
		end else if (hdr == HDR_DATA) begin
			word_avail = 1'b1;
			done = decode_bits(w);
		end
		if (n_pend > 0 || n_res == 0)
			flush_result();
		k = unpacked_q.size() - 1;
		unpacked_q[k].last = 1'b1;
		unpacked_q[k].done = done;
		unpacked_q[k].ok = done && (chk_acc == 0);
		unpacked_q[k].err = err_flag;
	endfunction

	task automatic report(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		shifter = '0;
		chk_acc = '0;
		left = '0;
		hdr = HDR_IDLE;
		phase = PH_PFX_A;
		facc = '0;
		fbits = 0;
		run_len = '0;
		distance = '0;
		wr_ptr = 0;
		produced = 0;
		err_flag = 1'b0;
		word_avail = 1'b0;
	end

	assign pending = unpacked_q.size();

	always @(posedge clk) begin
		unpacked_t e;
		if (arst_n && word_valid && !word_stall)
			unpack_word(stream_start, packed_word);
		if (arst_n && res_valid && !res_stall) begin
			if (unpacked_q.size() == 0) begin
				report("result with no request outstanding");
			end else begin
				e = unpacked_q.pop_front();
				if (bytes_low !== e.lo)
					report($sformatf("bytes_low %h exp %h", bytes_low, e.lo));
				if (bytes_high !== e.hi)
					report($sformatf("bytes_high %h exp %h", bytes_high, e.hi));
				if (byte_count !== e.cnt)
					report($sformatf("byte_count %0d exp %0d", byte_count, e.cnt));
				if (last_for_word !== e.last)
					report($sformatf("last_for_word %b exp %b", last_for_word, e.last));
				if (stream_done !== e.done)
					report($sformatf("stream_done %b exp %b", stream_done, e.done));
				if (check_ok !== e.ok)
					report($sformatf("check_ok %b exp %b", check_ok, e.ok));
				if (format_error !== e.err)
					report($sformatf("format_error %b exp %b", format_error, e.err));
			end
		end
	end

endmodule

// File: verif/backward_lz_bit_unpacker_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// backward_lz_bit_unpacker_top_test
// drives directed and random packed streams with random gaps and result
// stalls; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module backward_lz_bit_unpacker_top_test;
	import blu_pkg::*;

	localparam int unsigned WORD_TARGET = 270;

	logic        clk;
	logic        arst_n;
	logic        word_valid;
	logic        word_stall;
	logic        stream_start;
	logic [31:0] packed_word;
	logic        res_valid;
	logic        res_stall;
	logic [63:0] bytes_low;
	logic [63:0] bytes_high;
	logic [CNT_W-1:0] byte_count;
	logic        last_for_word;
	logic        stream_done;
	logic        check_ok;
	logic        format_error;
	int          fail_count;
	int          pending;

	logic        cmd_bits[$];
	int unsigned words_sent;
	logic        no_gaps;

	backward_lz_bit_unpacker_top u_top (
		.clk(clk), .arst_n(arst_n),
		.word_valid(word_valid), .word_stall(word_stall),
		.stream_start(stream_start), .packed_word(packed_word),
		.res_valid(res_valid), .res_stall(res_stall),
		.bytes_low(bytes_low), .bytes_high(bytes_high), .byte_count(byte_count),
		.last_for_word(last_for_word), .stream_done(stream_done),
		.check_ok(check_ok), .format_error(format_error)
	);

	backward_lz_bit_unpacker_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.word_valid(word_valid), .word_stall(word_stall),
		.stream_start(stream_start), .packed_word(packed_word),
		.res_valid(res_valid), .res_stall(res_stall),
		.bytes_low(bytes_low), .bytes_high(bytes_high), .byte_count(byte_count),
		.last_for_word(last_for_word), .stream_done(stream_done),
		.check_ok(check_ok), .format_error(format_error),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("TEST FAILED");
		$finish;
	end

	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// result stalls: mostly short, some long, with open stretches
	initial begin
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 9) < 3)
				res_stall <= 1'b1;
			else
				res_stall <= 1'b0;
			if ($urandom_range(0, 49) == 0)
				repeat ($urandom_range(10, 60)) @(posedge clk);
		end
	end

	task automatic send_word(input logic start, input logic [31:0] w);
		logic stalled;
		int unsigned g;
		stream_start <= start;
		packed_word <= w;
		word_valid <= 1'b1;
		do begin
			@(negedge clk);
			stalled = word_stall;
			@(posedge clk);
		end while (stalled);
		words_sent++;
		g = no_gaps ? 0 : gap_len();
		if (g != 0) begin
			word_valid <= 1'b0;
			stream_start <= 1'b0;
			packed_word <= $urandom();
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic put_val(input int unsigned v, input int unsigned n);
		for (int i = n - 1; i >= 0; i--)
			cmd_bits.push_back(1'((v >> i) & 1));
	endtask

	// packs the queued command bits into words; the first word carries a marker
	task automatic send_cmds(input logic [31:0] size, input logic good_check);
		logic [31:0] words[$];
		logic [31:0] w, x;
		int unsigned n;
		n = (cmd_bits.size() < 31) ? cmd_bits.size() : 31;
		w = '0;
		for (int i = 0; i < n; i++)
			w[i] = cmd_bits.pop_front();
		w[n] = 1'b1;
		words.push_back(w);
		while (cmd_bits.size() != 0) begin
			w = '0;
			for (int i = 0; i < 32 && cmd_bits.size() != 0; i++)
				w[i] = cmd_bits.pop_front();
			words.push_back(w);
		end
		x = '0;
		foreach (words[i])
			x ^= words[i];
		send_word(1'b1, size);
		send_word(1'b0, good_check ? x : ~x);
		foreach (words[i])
			send_word(1'b0, words[i]);
	endtask

	// random bit words, then zero words that keep the check sum intact
	task automatic rand_stream();
		logic [31:0] size, x;
		logic [31:0] body[$];
		int unsigned k, tail, r;
		r = $urandom_range(0, 99);
		if (r < 70)
			size = $urandom_range(0, 60);
		else if (r < 92)
			size = $urandom_range(61, 600);
		else if (r < 97)
			size = $urandom_range(601, 5000);
		else
			size = $urandom();
		k = (size > 60) ? $urandom_range(4, 20) : $urandom_range(1, 5);
		x = '0;
		for (int i = 0; i < k; i++) begin
			body.push_back($urandom());
			x ^= body[i];
		end
		if ($urandom_range(0, 4) == 0)
			x ^= $urandom();
		tail = (size > 60) ? 2 : size / 2 + 3;
		// cut the stream short now and then so the next start lands mid-stream
		if ($urandom_range(0, 9) == 0) begin
			k = $urandom_range(0, k);
			tail = 0;
		end
		send_word(1'b1, size);
		send_word(1'b0, x);
		for (int i = 0; i < k; i++)
			send_word(1'b0, body[i]);
		for (int i = 0; i < tail; i++)
			send_word(1'b0, 32'h0);
		if ($urandom_range(0, 7) == 0)
			send_word(1'b0, $urandom());
	endtask

	initial begin
		arst_n = 1'b0;
		word_valid = 1'b0;
		stream_start = 1'b0;
		packed_word = '0;
		words_sent = 0;
		no_gaps = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle word yields an empty closing result
		send_word(1'b0, 32'hFFFF_FFFF);

		// every command form, extreme bytes, zero and too-far distances
		put_val(0, 2); put_val(7, 3);
		put_val(8'hFF, 8); put_val(8'h00, 8); put_val(8'hA5, 8); put_val(8'h5A, 8);
		put_val(8'h01, 8); put_val(8'h80, 8); put_val(8'hFF, 8); put_val(8'h00, 8);
		put_val(1, 2); put_val(1, 8);
		put_val(4, 3); put_val(3, 9);
		put_val(5, 3); put_val(0, 10);
		put_val(6, 3); put_val(255, 8); put_val(12'hFFF, 12);
		put_val(7, 3); put_val(0, 8);
		for (int i = 0; i < 9; i++)
			put_val(i * 29, 8);
		send_cmds(32'd282, 1'b1);

		// size zero overruns its only command
		put_val(0, 2); put_val(0, 3); put_val(8'h33, 8);
		send_cmds(32'd0, 1'b1);

		// copy before any byte exists, then a literal run that overruns
		put_val(1, 2); put_val(5, 8);
		put_val(0, 2); put_val(3, 3);
		put_val(8'h11, 8); put_val(8'h22, 8);
		send_cmds(32'd3, 1'b0);

		// restart in the middle of the header
		send_word(1'b1, 32'd10);
		send_word(1'b0, 32'hDEAD_BEEF);

		while (words_sent < WORD_TARGET) begin
			no_gaps = ($urandom_range(0, 4) == 0);
			rand_stream();
		end
		no_gaps = 1'b0;
		word_valid <= 1'b0;
		stream_start <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (1200) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
